FILE: sv/dsch_pkg.sv
// Package: types, codes and helper functions for the disk request scheduler.
package dsch_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef logic [IW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_PICK = 1'b1;

	localparam logic [1:0] STS_ADDED   = 2'd0;
	localparam logic [1:0] STS_DROPPED = 2'd1;
	localparam logic [1:0] STS_GRANTED = 2'd2;
	localparam logic [1:0] STS_EMPTY   = 2'd3;

	localparam logic [2:0] POL_FIFO  = 3'd0;
	localparam logic [2:0] POL_SSTF  = 3'd1;
	localparam logic [2:0] POL_LOOK  = 3'd2;
	localparam logic [2:0] POL_CLOOK = 3'd3;
	localparam logic [2:0] POL_FLOOK = 3'd4;

	typedef struct packed {
		logic        op;
		logic [15:0] req_id;
		logic [15:0] req_track;
		logic [15:0] head_track;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] grant_id;
		logic [15:0] grant_track;
		logic        dir_down;
		logic        batch_swapped;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [15:0] track;
		logic        batch;
	} ent_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic        pv;
		idx_t        pos;
		logic [15:0] pd;
		logic        nv;
		idx_t        neg;
		logic [15:0] nd;
	} look_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_READ
	} state_t;

	// Fold one entry into the nearest-above / nearest-below trackers.
	function automatic look_t look_step(look_t l, logic [15:0] t, logic [15:0] h, idx_t i);
		look_t r;
		logic [15:0] d;
		r = l;
		d = '0;
		if (t == h) begin
			r.pv = 1'b1; r.pos = i; r.pd = '0;
			r.nv = 1'b1; r.neg = i; r.nd = '0;
		end else if (t > h) begin
			d = t - h;
			if (!l.pv || d < l.pd) begin
				r.pv = 1'b1; r.pos = i; r.pd = d;
			end
		end else begin
			d = h - t;
			if (!l.nv || d < l.nd) begin
				r.nv = 1'b1; r.neg = i; r.nd = d;
			end
		end
		return r;
	endfunction

	// Choose in the sweep direction, reversing when nothing lies that way.
	function automatic idx_t look_choose(look_t l, logic dir_down);
		idx_t r;
		r = '0;
		if (!dir_down) begin
			if (l.pv) r = l.pos;
			else if (l.nv) r = l.neg;
		end else begin
			if (l.nv) r = l.neg;
			else if (l.pv) r = l.pos;
		end
		return r;
	endfunction

endpackage

FILE: sv/dsch_cell.sv
// One table cell: holds a pending request and takes its upper neighbor on compaction.
module dsch_cell import dsch_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  ent_t      din,
	input  ent_t      nbr,
	output ent_t      ent
);

	logic        valid_q;
	logic [15:0] id_q;
	logic [15:0] track_q;
	logic        batch_q;

	// Valid bit: cleared under reset, set on load, taken from the neighbor on shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (ctl.shift) begin
			valid_q <= nbr.valid;
		end
	end

	// Load a new request or advance the neighbor's payload.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q    <= din.id;
			track_q <= din.track;
			batch_q <= din.batch;
		end else if (ctl.shift) begin
			id_q    <= nbr.id;
			track_q <= nbr.track;
			batch_q <= nbr.batch;
		end
	end

	assign ent = '{valid: valid_q, id: id_q, track: track_q, batch: batch_q};

endmodule

FILE: sv/disk_request_scheduler_top.sv
// Top level: disk request scheduler with a compacting row of request cells.
//
// Usage: drive cmd and raise start while busy is low; the item transfers at
// that edge. One result per item appears on rsp for exactly one cycle with
// done high; the receiver cannot stall it.
// The table is a row of TABLE_DEPTH cells kept in arrival order; a grant
// removes one cell and every cell above it takes its upper neighbor's entry.
// An add, a dropped add or a pick on an empty table gives its result in the
// cycle after the transfer, and busy stays low.
// A pick with n pending requests scans the cells one per cycle through a
// single read port, then decides and reads the winner in S_DECIDE and S_READ;
// result in the first cycle with busy low; a new item may transfer in that cycle.
// policy_q is set through cfg_we / cfg_wdata; write it only while the block is
// idle, which the block itself does not enforce. Reset empties the table, sets
// the sweep upward, the active batch to one and the policy to FIFO.
module disk_request_scheduler_top import dsch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata
);

	state_t      state_q, state_d;
	cnt_t        count_q;
	idx_t        cnt_q;
	idx_t        sel_q;
	logic [2:0]  policy_q;
	logic        dir_q;
	logic        ab_q;
	logic        swapped_q;
	logic [15:0] head_q;
	logic        done_q;
	rsp_t        rsp_q;
	look_t       look_q [3];
	logic        bv_q;
	idx_t        best_q;
	logic [15:0] bd_q;
	logic        cv_q;
	idx_t        cpos_q;
	logic [15:0] cd_q;
	logic        lv_q;
	idx_t        low_q;
	logic [15:0] lt_q;

	ent_t        ents [TABLE_DEPTH];
	cell_ctl_t   ctls [TABLE_DEPTH];
	ent_t        new_ent;
	ent_t        rd;
	idx_t        addr;
	logic        accept;
	logic        add_en;
	logic        rm_en;
	idx_t        sel_d;
	logic        nab;
	logic        any_act;
	logic [15:0] t;
	logic [15:0] seek;

	assign accept  = start && !busy;
	assign add_en  = accept && cmd.op == OP_ADD && count_q != cnt_t'(TABLE_DEPTH);
	assign new_ent = '{valid: 1'b1, id: cmd.req_id, track: cmd.req_track, batch: ~ab_q};

	// Cell row: compaction moves each entry from the removed slot upward down one place.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ent_t nbr;
		if (i == TABLE_DEPTH - 1) begin : g_top
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = ents[i+1];
		end
		assign ctls[i].load  = add_en && count_q == cnt_t'(i);
		assign ctls[i].shift = rm_en && sel_q <= idx_t'(i);
		dsch_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctls[i]),
			.din    (new_ent),
			.nbr    (nbr),
			.ent    (ents[i])
		);
	end

	// Single read port over the row.
	assign addr = (state_q == S_SCAN) ? cnt_q : sel_q;
	assign rd   = ents[addr];
	assign t    = rd.track;
	assign seek = (t >= head_q) ? t - head_q : head_q - t;

	// Next state and compaction enable.
	always_comb begin
		state_d = state_q;
		rm_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.op == OP_PICK && count_q != '0) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (cnt_t'(cnt_q) == count_q - cnt_t'(1)) state_d = S_DECIDE;
			end
			S_DECIDE: state_d = S_READ;
			S_READ: begin
				rm_en   = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Decide the winner from the scan trackers.
	always_comb begin
		any_act = look_q[{1'b0, ab_q}].pv || look_q[{1'b0, ab_q}].nv;
		nab     = any_act ? ab_q : ~ab_q;
		sel_d   = '0;
		case (policy_q)
			POL_SSTF:  sel_d = best_q;
			POL_LOOK:  sel_d = look_choose(look_q[2], dir_q);
			POL_CLOOK: sel_d = cv_q ? cpos_q : low_q;
			POL_FLOOK: sel_d = look_choose(look_q[{1'b0, nab}], dir_q);
			default:   sel_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
		end else begin
			state_q  <= state_d;
		end
	end

	// Control registers: fill count, policy, direction, batch, swap flag, strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			policy_q  <= POL_FIFO;
			dir_q     <= 1'b0;
			ab_q      <= 1'b1;
			done_q    <= 1'b0;
			swapped_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) policy_q <= cfg_wdata;
			if (accept && (cmd.op == OP_ADD || count_q == '0)) done_q <= 1'b1;
			if (add_en) count_q <= count_q + cnt_t'(1);
			if (state_q == S_DECIDE) begin
				swapped_q <= 1'b0;
				if (policy_q == POL_FLOOK && !any_act) begin
					ab_q      <= ~ab_q;
					swapped_q <= 1'b1;
				end
			end
			if (state_q == S_READ) begin
				count_q <= count_q - cnt_t'(1);
				done_q  <= 1'b1;
				if (rd.track > head_q) dir_q <= 1'b0;
				else if (rd.track < head_q) dir_q <= 1'b1;
			end
		end
	end

	// Scan datapath and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= cmd.head_track;
			cnt_q  <= '0;
			for (int k = 0; k < 3; k++) begin
				look_q[k].pv <= 1'b0;
				look_q[k].nv <= 1'b0;
			end
			bv_q <= 1'b0;
			cv_q <= 1'b0;
			lv_q <= 1'b0;
			rsp_q.grant_id      <= '0;
			rsp_q.grant_track   <= '0;
			rsp_q.dir_down      <= dir_q;
			rsp_q.batch_swapped <= 1'b0;
			if (cmd.op == OP_ADD) rsp_q.status <= add_en ? STS_ADDED : STS_DROPPED;
			else rsp_q.status <= STS_EMPTY;
		end
		if (state_q == S_SCAN) begin
			cnt_q     <= cnt_q + idx_t'(1);
			look_q[2] <= look_step(look_q[2], t, head_q, cnt_q);
			if (rd.batch) look_q[1] <= look_step(look_q[1], t, head_q, cnt_q);
			else look_q[0] <= look_step(look_q[0], t, head_q, cnt_q);
			if (!bv_q || seek < bd_q) begin
				bv_q <= 1'b1; best_q <= cnt_q; bd_q <= seek;
			end
			if (t >= head_q) begin
				if (!cv_q || t - head_q < cd_q) begin
					cv_q <= 1'b1; cpos_q <= cnt_q; cd_q <= t - head_q;
				end
			end else if (!lv_q || t < lt_q) begin
				lv_q <= 1'b1; low_q <= cnt_q; lt_q <= t;
			end
		end
		if (state_q == S_DECIDE) sel_q <= sel_d;
		if (state_q == S_READ) begin
			rsp_q.status        <= STS_GRANTED;
			rsp_q.grant_id      <= rd.id;
			rsp_q.grant_track   <= rd.track;
			rsp_q.batch_swapped <= swapped_q;
			if (rd.track > head_q) rsp_q.dir_down <= 1'b0;
			else if (rd.track < head_q) rsp_q.dir_down <= 1'b1;
			else rsp_q.dir_down <= dir_q;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(TABLE_DEPTH))
		else $error("fill count beyond table depth");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		add_en |=> count_q == $past(count_q) + cnt_t'(1))
		else $error("accepted add did not grow the table");
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> done && rsp.status == STS_GRANTED)
		else $error("grant not delivered after read");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> count_q != '0)
		else $error("scan running on an empty table");
`endif

endmodule

FILE: bench/disk_request_scheduler_top_tb.sv
// Testbench: disk request scheduler checked against a built-in scheduling predictor.
module disk_request_scheduler_top_tb;
	import dsch_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	cmd_t       cmd = '0;
	logic       done;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_wdata = '0;

	localparam int IDLE_LIMIT = 5000;

	// Predictor copy of the request table and scheduler state
	logic [15:0] pend_id [TABLE_DEPTH];
	logic [15:0] pend_trk [TABLE_DEPTH];
	logic        pend_bat [TABLE_DEPTH];
	int          pend_cnt = 0;
	logic        act_bat = 1'b1;
	logic        sweep_down = 1'b0;
	logic [2:0]  policy = POL_FIFO;

	rsp_t grant_q[$];
	int   err_cnt = 0;
	int   idle_cycles = 0;

	disk_request_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Nearest request in the sweep direction; reverse when none lies that way
	function automatic int look_pick(int unsigned h, bit batched);
		int pos, neg;
		int unsigned pd, nd, t, d;
		pos = -1; neg = -1; pd = 0; nd = 0;
		for (int i = 0; i < pend_cnt; i++) begin
			if (batched && pend_bat[i] != act_bat) continue;
			t = 32'(pend_trk[i]);
			if (t == h) begin
				pos = i; neg = i; pd = 0; nd = 0;
			end else if (t > h) begin
				d = t - h;
				if (pos < 0 || d < pd) begin pos = i; pd = d; end
			end else begin
				d = h - t;
				if (neg < 0 || d < nd) begin neg = i; nd = d; end
			end
		end
		if (!sweep_down) begin
			if (pos >= 0) return pos;
			sweep_down = 1'b1;
			return neg;
		end
		if (neg >= 0) return neg;
		sweep_down = 1'b0;
		return pos;
	endfunction

	// Work out the result of one transferred command and update the table
	function automatic rsp_t schedule(cmd_t c);
		rsp_t r;
		int sel, best, low, pos;
		int unsigned bd, pd, t, d, h;
		bit any;
		r = '0;
		sel = 0;
		h = 32'(c.head_track);
		if (c.op == OP_ADD) begin
			if (pend_cnt >= TABLE_DEPTH) begin
				r.status = STS_DROPPED;
			end else begin
				pend_id[pend_cnt] = c.req_id;
				pend_trk[pend_cnt] = c.req_track;
				pend_bat[pend_cnt] = ~act_bat;
				pend_cnt++;
				r.status = STS_ADDED;
			end
		end else if (pend_cnt == 0) begin
			r.status = STS_EMPTY;
		end else begin
			case (policy)
				POL_SSTF: begin
					best = -1; bd = 0;
					for (int i = 0; i < pend_cnt; i++) begin
						t = 32'(pend_trk[i]);
						d = t >= h ? t - h : h - t;
						if (best < 0 || d < bd) begin best = i; bd = d; end
					end
					sel = best;
				end
				POL_LOOK: sel = look_pick(h, 1'b0);
				POL_CLOOK: begin
					pos = -1; low = -1; pd = 0;
					for (int i = 0; i < pend_cnt; i++) begin
						t = 32'(pend_trk[i]);
						if (t >= h) begin
							if (pos < 0 || t - h < pd) begin pos = i; pd = t - h; end
						end else if (low < 0 || pend_trk[i] < pend_trk[low]) begin
							low = i;
						end
					end
					sel = pos >= 0 ? pos : low;
				end
				POL_FLOOK: begin
					any = 0;
					for (int i = 0; i < pend_cnt; i++)
						if (pend_bat[i] == act_bat) any = 1;
					if (!any) begin
						act_bat = ~act_bat;
						r.batch_swapped = 1'b1;
					end
					sel = look_pick(h, 1'b1);
				end
				default: sel = 0;
			endcase
			if (sel < 0 || sel >= pend_cnt) sel = 0;
			r.grant_id = pend_id[sel];
			r.grant_track = pend_trk[sel];
			if (pend_trk[sel] > c.head_track) sweep_down = 1'b0;
			else if (pend_trk[sel] < c.head_track) sweep_down = 1'b1;
			// Compact the table toward slot 0
			for (int i = sel; i + 1 < pend_cnt; i++) begin
				pend_id[i] = pend_id[i + 1];
				pend_trk[i] = pend_trk[i + 1];
				pend_bat[i] = pend_bat[i + 1];
			end
			pend_cnt--;
			r.status = STS_GRANTED;
		end
		r.dir_down = sweep_down;
		return r;
	endfunction

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		if (done) begin
			if (grant_q.size() == 0) begin
				$error("unexpected result status=%0d", rsp.status);
				err_cnt++;
			end else begin
				rsp_t e;
				e = grant_q.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, rsp.status);
					err_cnt++;
				end
				if (rsp.grant_id !== e.grant_id) begin
					$error("grant_id: expected %0h, actual %0h", e.grant_id, rsp.grant_id);
					err_cnt++;
				end
				if (rsp.grant_track !== e.grant_track) begin
					$error("grant_track: expected %0h, actual %0h", e.grant_track,
						rsp.grant_track);
					err_cnt++;
				end
				if (rsp.dir_down !== e.dir_down) begin
					$error("dir_down: expected %0b, actual %0b", e.dir_down, rsp.dir_down);
					err_cnt++;
				end
				if (rsp.batch_swapped !== e.batch_swapped) begin
					$error("batch_swapped: expected %0b, actual %0b", e.batch_swapped,
						rsp.batch_swapped);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run after a long stretch with no transfer and no result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one command after a random gap; return at the falling edge after transfer
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd = c;
		start = 1'b1;
		do @(posedge clk); while (busy);
		grant_q = {grant_q, schedule(c)};
		@(negedge clk);
	endtask

	task automatic add_req(logic [15:0] id, logic [15:0] trk);
		cmd_t c;
		c = '0;
		c.op = OP_ADD;
		c.req_id = id;
		c.req_track = trk;
		c.head_track = 16'($urandom());
		send_cmd(c);
	endtask

	task automatic pick_req(logic [15:0] h);
		cmd_t c;
		c = '0;
		c.op = OP_PICK;
		c.req_id = 16'($urandom());
		c.req_track = 16'($urandom());
		c.head_track = h;
		send_cmd(c);
	endtask

	// Hold off until every expected result has arrived and the block settles
	task automatic drain();
		start = 1'b0;
		while (grant_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_policy(logic [2:0] mode);
		drain();
		cfg_wdata = mode;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		policy = mode;
	endtask

	// Extreme, clustered (so ties and head hits occur) and full-range tracks
	function automatic logic [15:0] rand_track();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'd1000 + 16'($urandom_range(0, 8));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic test_directed();
		set_policy(POL_FIFO);
		pick_req(16'h0000);
		add_req(16'h0000, 16'h0000);
		add_req(16'hFFFF, 16'hFFFF);
		add_req(16'h5A5A, 16'd1000);
		pick_req(16'hFFFF);
		set_policy(POL_SSTF);
		add_req(16'h0001, 16'd1002);
		add_req(16'h0002, 16'd998);
		pick_req(16'd1000);
		set_policy(POL_LOOK);
		add_req(16'h0003, 16'd1000);
		add_req(16'h0004, 16'd1000);
		pick_req(16'd1000);
		pick_req(16'd1001);
		pick_req(16'd1001);
		set_policy(POL_CLOOK);
		add_req(16'h0005, 16'd10);
		add_req(16'h0006, 16'd5);
		pick_req(16'd20);
		pick_req(16'd20);
		set_policy(3'd7);
		pick_req(16'd20);
	endtask

	// Fill past capacity so adds are dropped, then drain under batched look
	task automatic test_table_full();
		set_policy(POL_FLOOK);
		for (int i = 0; i <= TABLE_DEPTH; i++) add_req(16'($urandom()), rand_track());
		for (int i = 0; i <= TABLE_DEPTH; i++) pick_req(rand_track());
	endtask

	task automatic test_policy_random(logic [2:0] mode, int count, bit pause);
		int add_pct;
		set_policy(mode);
		add_pct = $urandom_range(35, 70);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) add_pct = $urandom_range(30, 75);
			if (pause && i == count / 2) drain();
			if ($urandom_range(0, 99) < add_pct) add_req(16'($urandom()), rand_track());
			else pick_req(rand_track());
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_policy_random(POL_FIFO, 90, 1'b0);
		test_policy_random(POL_SSTF, 130, 1'b1);
		test_policy_random(POL_LOOK, 130, 1'b0);
		test_policy_random(POL_CLOOK, 130, 1'b0);
		test_policy_random(POL_FLOOK, 160, 1'b0);
		test_policy_random(3'd5, 40, 1'b0);
		test_policy_random(3'd6, 40, 1'b0);
		test_policy_random(POL_LOOK, 60, 1'b0);
		start = 1'b0;
		while (grant_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
